FILE: rtl/core/bfsp_pkg.sv
// Shared types and constants for the shortest path engine.
// Holds the item structs, command codes and controller/datapath signal groups.
// No dependencies.
package bfsp_pkg;

    localparam int CMD_W       = 2;
    localparam int VTX_W       = 6;
    localparam int WEIGHT_IN_W = 16;
    localparam int DIST_W      = 24;
    localparam int CFG_W       = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

    localparam int DIST_MAX = 8388607;
    localparam int DIST_MIN = -8388608;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [VTX_W-1:0]       source_vertex;
        logic [VTX_W-1:0]       target_vertex;
        logic [WEIGHT_IN_W-1:0] edge_weight;
        logic [VTX_W-1:0]       start_vertex;
    } bfsp_in_t;

    typedef struct packed {
        logic [VTX_W-1:0]         vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     reached;
        logic                     last;
    } bfsp_out_t;

    typedef struct packed {
        logic clear_edges;
        logic load_edge;
        logic run_begin;
        logic init_write;
        logic relax_sum;
        logic relax_write;
        logic out_read;
        logic out_emit;
    } bfsp_cmd_t;

    typedef struct packed {
        logic vtx_last;
        logic edge_last;
        logic pass_last;
        logic no_relax;
    } bfsp_status_t;

endpackage

FILE: rtl/core/bfsp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bfsp_ctrl.sv
// Controller state machine for the shortest path engine.
// Sequences edge loading, distance initialization, relaxation and readout.
// Depends on bfsp_pkg.
module bfsp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             command,
    input  bfsp_pkg::bfsp_status_t status,
    output bfsp_pkg::bfsp_cmd_t    cmd,
    output logic                   busy
);

    import bfsp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_LOOK   = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_OREAD  = 3'd6;
    localparam logic [2:0] ST_OEMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.clear_edges = (command == CMD_CLEAR);
                    cmd.load_edge   = (command == CMD_ADD);
                    cmd.run_begin   = (command == CMD_RUN);
                    if (command == CMD_RUN)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_write = 1'b1;
                if (status.vtx_last)
                begin
                    state_next = status.no_relax ? ST_OREAD : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.relax_sum = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.relax_write = 1'b1;
                state_next = (status.edge_last && status.pass_last) ? ST_OREAD : ST_FETCH;
            end
            ST_OREAD:
            begin
                cmd.out_read = 1'b1;
                state_next   = ST_OEMIT;
            end
            ST_OEMIT:
            begin
                cmd.out_emit = 1'b1;
                state_next   = status.vtx_last ? ST_IDLE : ST_OREAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/core/bfsp_datapath.sv
// Datapath of the shortest path engine: edge store, distance stores, counters,
// saturating relaxation and the result register. Depends on bfsp_pkg and bfsp_ram.
module bfsp_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bfsp_pkg::bfsp_cmd_t    cmd,
    input  bfsp_pkg::bfsp_in_t     request,
    input  logic                   cfg_we,
    input  logic [6:0]             cfg_data,
    output bfsp_pkg::bfsp_status_t status,
    output logic                   result_valid,
    output bfsp_pkg::bfsp_out_t    result
);

    import bfsp_pkg::*;

    localparam int VAW   = $clog2(MAX_VERTICES);
    localparam int NCW   = $clog2(MAX_VERTICES + 1);
    localparam int EAW   = $clog2(MAX_EDGES);
    localparam int ECW   = $clog2(MAX_EDGES + 1);
    localparam int EW    = 2 * VTX_W + WEIGHT_BITS;
    localparam int DW    = DIST_W + 1;
    localparam int SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(DIST_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(DIST_MIN);

    logic [CFG_W-1:0]         vertex_count_reg;
    logic [ECW-1:0]           edge_total_reg;
    logic [ECW-1:0]           edge_total_next;
    logic [NCW-1:0]           n_reg;
    logic [NCW-1:0]           n_next;
    logic [VTX_W-1:0]         start_reg;
    logic [VAW-1:0]           v_idx_reg;
    logic [VAW-1:0]           v_idx_next;
    logic [EAW-1:0]           e_idx_reg;
    logic [EAW-1:0]           e_idx_next;
    logic [NCW-1:0]           pass_reg;
    logic [NCW-1:0]           pass_next;
    logic signed [DIST_W-1:0] sum_reg;
    logic signed [DIST_W-1:0] sum_next;
    logic                     edge_ok_reg;
    logic                     edge_ok_next;
    logic                     result_valid_reg;
    bfsp_out_t                result_reg;

    logic                     edge_full;
    logic                     edge_we;
    logic [EW-1:0]            edge_wdata;
    logic [EW-1:0]            edge_rdata;
    logic [VTX_W-1:0]         e_tail;
    logic [VTX_W-1:0]         e_head;
    logic signed [WEIGHT_BITS-1:0] e_cost;

    logic                     dist_we;
    logic [VAW-1:0]           dist_waddr;
    logic [DW-1:0]            dist_wdata;
    logic [VAW-1:0]           dist_raddr_a;
    logic [VAW-1:0]           dist_raddr_b;
    logic [DW-1:0]            dist_rdata_a;
    logic [DW-1:0]            dist_rdata_b;
    logic                     reach_a;
    logic                     reach_b;
    logic signed [DIST_W-1:0] dist_a;
    logic signed [DIST_W-1:0] dist_b;
    logic signed [SUM_W-1:0]  sum_wide;
    logic                     take;
    logic                     start_hit;

    // Edge store: one word per edge holding tail, head and raw weight bits.
    assign edge_full  = (edge_total_reg == ECW'(MAX_EDGES));
    assign edge_we    = cmd.load_edge && !edge_full;
    assign edge_wdata = {request.source_vertex, request.target_vertex,
                         WEIGHT_BITS'(request.edge_weight)};

    bfsp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_total_reg[EAW-1:0]),
        .wdata (edge_wdata),
        .raddr (e_idx_reg),
        .rdata (edge_rdata)
    );

    assign e_tail = edge_rdata[EW-1 -: VTX_W];
    assign e_head = edge_rdata[WEIGHT_BITS+VTX_W-1 -: VTX_W];
    assign e_cost = $signed(edge_rdata[WEIGHT_BITS-1:0]);

    // Two copies of the distance store so tail and head can be read together.
    assign start_hit    = (32'(start_reg) == 32'(v_idx_reg));
    assign dist_we      = cmd.init_write || (cmd.relax_write && take);
    assign dist_waddr   = cmd.init_write ? v_idx_reg : VAW'(e_head);
    assign dist_wdata   = cmd.init_write ? {start_hit, {DIST_W{1'b0}}} : {1'b1, sum_reg};
    assign dist_raddr_a = cmd.out_read ? v_idx_reg : VAW'(e_tail);
    assign dist_raddr_b = VAW'(e_head);

    bfsp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr_a),
        .rdata (dist_rdata_a)
    );

    bfsp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr_b),
        .rdata (dist_rdata_b)
    );

    assign reach_a = dist_rdata_a[DW-1];
    assign reach_b = dist_rdata_b[DW-1];
    assign dist_a  = $signed(dist_rdata_a[DIST_W-1:0]);
    assign dist_b  = $signed(dist_rdata_b[DIST_W-1:0]);

    assign sum_wide = SUM_W'(dist_a) + SUM_W'(e_cost);
    assign take     = edge_ok_reg && (!reach_b || (sum_reg < dist_b));

    assign status.vtx_last  = ((NCW'(v_idx_reg) + NCW'(1)) == n_reg);
    assign status.edge_last = ((ECW'(e_idx_reg) + ECW'(1)) == edge_total_reg);
    assign status.pass_last = ((pass_reg + NCW'(1)) == n_reg);
    assign status.no_relax  = (n_reg == NCW'(1)) || (edge_total_reg == '0);

    always_comb
    begin
        edge_total_next = edge_total_reg;
        if (cmd.clear_edges)
        begin
            edge_total_next = '0;
        end
        else if (edge_we)
        begin
            edge_total_next = edge_total_reg + ECW'(1);
        end

        if (vertex_count_reg == '0)
        begin
            n_next = NCW'(1);
        end
        else if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
        begin
            n_next = NCW'(MAX_VERTICES);
        end
        else
        begin
            n_next = NCW'(vertex_count_reg);
        end

        v_idx_next = v_idx_reg;
        if (cmd.run_begin)
        begin
            v_idx_next = '0;
        end
        else if (cmd.init_write || cmd.out_emit)
        begin
            v_idx_next = status.vtx_last ? '0 : v_idx_reg + VAW'(1);
        end

        e_idx_next = e_idx_reg;
        pass_next  = pass_reg;
        if (cmd.run_begin)
        begin
            e_idx_next = '0;
            pass_next  = NCW'(1);
        end
        else if (cmd.relax_write)
        begin
            if (status.edge_last)
            begin
                e_idx_next = '0;
                pass_next  = pass_reg + NCW'(1);
            end
            else
            begin
                e_idx_next = e_idx_reg + EAW'(1);
            end
        end

        if (sum_wide > SAT_HI)
        begin
            sum_next = DIST_W'(SAT_HI);
        end
        else if (sum_wide < SAT_LO)
        begin
            sum_next = DIST_W'(SAT_LO);
        end
        else
        begin
            sum_next = DIST_W'(sum_wide);
        end
        edge_ok_next = (32'(e_tail) < 32'(n_reg)) && (32'(e_head) < 32'(n_reg)) && reach_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CFG_RESET;
            edge_total_reg   <= '0;
            n_reg            <= NCW'(1);
            v_idx_reg        <= '0;
            e_idx_reg        <= '0;
            pass_reg         <= NCW'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_data;
            end
            edge_total_reg <= edge_total_next;
            if (cmd.run_begin)
            begin
                n_reg <= n_next;
            end
            v_idx_reg        <= v_idx_next;
            e_idx_reg        <= e_idx_next;
            pass_reg         <= pass_next;
            result_valid_reg <= cmd.out_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run_begin)
        begin
            start_reg <= request.start_vertex;
        end
        if (cmd.relax_sum)
        begin
            sum_reg     <= sum_next;
            edge_ok_reg <= edge_ok_next;
        end
        if (cmd.out_emit)
        begin
            result_reg.vertex   <= VTX_W'(v_idx_reg);
            result_reg.distance <= reach_a ? dist_a : '0;
            result_reg.reached  <= reach_a;
            result_reg.last     <= status.vtx_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/bellman_ford_shortest_path.sv
// Single-source shortest path engine. Clear and add items are taken without raising busy.
// A run item is busy for the init state over all N vertices, N - 1 relaxation passes
// taking each edge through FETCH, LOOK, SUM and UPDATE (edge and distance RAM reads
// are registered) and readout through OREAD and OEMIT per vertex; the last result
// is valid in the first cycle with busy low. Results cannot be stalled by the receiver.
// Reset sets the edge count to zero and vertex_count to 16; RAM contents are not cleared.
module bellman_ford_shortest_path #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bfsp_pkg::bfsp_in_t  request,
    output logic                result_valid,
    output bfsp_pkg::bfsp_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    import bfsp_pkg::*;

    bfsp_cmd_t    cmd;
    bfsp_status_t status;

    assign cfg_ready = 1'b1;

    bfsp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    bfsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result item without a run in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command == CMD_RUN)) |=> busy)
        else $error("run item accepted but engine not busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command != CMD_RUN)) |=> !busy)
        else $error("edge store item left the engine busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result item follows the last item of a run");

endmodule
